/* rtl/u2u_pkg.sv */
package u2u_pkg;

    typedef logic [20:0] t_cp;
    typedef logic [15:0] t_unit;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;   // 0xD800..0xDBFF
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;   // 0xDC00..0xDFFF
    localparam t_cp        CP_SUPP_BASE  = 21'h010000;
    localparam t_cp        CP_REPLACE    = 21'h00FFFD;
    localparam t_cp        CP_LIM_1B     = 21'h000080;
    localparam t_cp        CP_LIM_2B     = 21'h000800;

    // encoded length minus one
    localparam logic [1:0] LEN_1B = 2'd0;
    localparam logic [1:0] LEN_2B = 2'd1;
    localparam logic [1:0] LEN_3B = 2'd2;
    localparam logic [1:0] LEN_4B = 2'd3;

    typedef struct packed {
        logic push;
        t_cp  cp;
    } t_q_push;

    typedef struct packed {
        logic valid;
        t_cp  cp;
    } t_q_head;

    function automatic logic [1:0] utf8_len(input t_cp cp);
        logic [1:0] len;
        if (cp < CP_LIM_1B) begin
            len = LEN_1B;
        end else if (cp < CP_LIM_2B) begin
            len = LEN_2B;
        end else if (cp < CP_SUPP_BASE) begin
            len = LEN_3B;
        end else begin
            len = LEN_4B;
        end
        return len;
    endfunction

    function automatic logic [7:0] utf8_byte(input t_cp cp, input logic [1:0] len,
                                             input logic [1:0] idx);
        logic [7:0] b;
        logic [1:0] remain;
        remain = len - idx;
        if (idx == 2'd0) begin
            unique case (len)
                LEN_1B:  b = cp[7:0];
                LEN_2B:  b = {3'b110, cp[10:6]};
                LEN_3B:  b = {4'b1110, cp[15:12]};
                default: b = {5'b11110, cp[20:18]};
            endcase
        end else begin
            unique case (remain)
                2'd0:    b = {2'b10, cp[5:0]};
                2'd1:    b = {2'b10, cp[11:6]};
                default: b = {2'b10, cp[17:12]};
            endcase
        end
        return b;
    endfunction

endpackage

/* rtl/u2u_in_if.sv */
interface u2u_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_last;

    modport source(output valid, in_byte, stream_last, input ready);
    modport sink(input valid, in_byte, stream_last, output ready);
endinterface

/* rtl/u2u_out_if.sv */
interface u2u_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source(output valid, out_byte, run_last, input ready);
    modport sink(input valid, out_byte, run_last, output ready);
endinterface

/* rtl/u2u_front.sv */
module u2u_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_data,
    u2u_in_if.sink           i_in,
    input  logic             i_q_full,
    output u2u_pkg::t_q_push o_push
);

    logic        r_big_endian;
    logic [7:0]  r_held;
    logic        r_have_half;
    logic [9:0]  r_high;
    logic        r_have_high;

    logic [7:0]  n_held;
    logic        n_have_half;
    logic [9:0]  n_high;
    logic        n_have_high;

    logic           accept;
    logic           emit;
    u2u_pkg::t_cp   cp;
    u2u_pkg::t_unit unit;
    logic           is_high;
    logic           is_low;

    assign o_cfg_ready = 1'b1;
    assign i_in.ready  = !i_q_full;
    assign accept      = i_in.valid && i_in.ready;

    assign unit    = r_big_endian ? {r_held, i_in.in_byte} : {i_in.in_byte, r_held};
    assign is_high = (unit[15:10] == u2u_pkg::SURR_HIGH_TAG);
    assign is_low  = (unit[15:10] == u2u_pkg::SURR_LOW_TAG);

    always_comb begin
        n_held      = r_held;
        n_have_half = r_have_half;
        n_high      = r_high;
        n_have_high = r_have_high;
        emit        = 1'b0;
        cp          = u2u_pkg::CP_REPLACE;
        if (accept) begin
            if (!r_have_half) begin
                n_held      = i_in.in_byte;
                n_have_half = 1'b1;
                // pending high surrogate cut off by stream end
                emit        = i_in.stream_last && r_have_high;
            end else begin
                n_have_half = 1'b0;
                if (r_have_high) begin
                    emit        = 1'b1;
                    n_have_high = 1'b0;
                    if (is_low) begin
                        cp = {1'b0, r_high, unit[9:0]} + u2u_pkg::CP_SUPP_BASE;
                    end
                end else if (is_high) begin
                    if (i_in.stream_last) begin
                        emit = 1'b1;
                    end else begin
                        n_high      = unit[9:0];
                        n_have_high = 1'b1;
                    end
                end else if (is_low) begin
                    emit = 1'b1;
                end else begin
                    emit = 1'b1;
                    cp   = {5'd0, unit};
                end
            end
            if (i_in.stream_last) begin
                n_held      = 8'd0;
                n_have_half = 1'b0;
                n_high      = 10'd0;
                n_have_high = 1'b0;
            end
        end
    end

    assign o_push.push = emit;
    assign o_push.cp   = cp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian <= 1'b0;
            r_held       <= 8'd0;
            r_have_half  <= 1'b0;
            r_high       <= 10'd0;
            r_have_high  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_big_endian <= i_cfg_data;
            end
            r_held      <= n_held;
            r_have_half <= n_have_half;
            r_high      <= n_high;
            r_have_high <= n_have_high;
        end
    end

endmodule

/* rtl/u2u_queue.sv */
module u2u_queue #(
    parameter int DEPTH = u2u_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  u2u_pkg::t_q_push i_push,
    input  logic             i_pop,
    output logic             o_full,
    output u2u_pkg::t_q_head o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u2u_pkg::t_cp     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic             push;
    logic             pop;

    assign push   = i_push.push && !o_full;
    assign pop    = i_pop && (r_count != '0);
    assign o_full = (r_count == CNT_W'(DEPTH));

    assign o_head.valid = (r_count != '0);
    assign o_head.cp    = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.cp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not follow a push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers differ while empty");

endmodule

/* rtl/u2u_back.sv */
module u2u_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  u2u_pkg::t_q_head i_head,
    output logic             o_pop,
    u2u_out_if.source        o_out
);

    logic         r_busy;
    u2u_pkg::t_cp r_cp;
    logic [1:0]   r_len;
    logic [1:0]   r_idx;

    logic         last_byte;
    logic         xfer;
    logic         load;

    assign last_byte = (r_idx == r_len);
    assign xfer      = o_out.valid && o_out.ready;
    assign load      = i_head.valid && (!r_busy || (xfer && last_byte));
    assign o_pop     = load;

    assign o_out.valid    = r_busy;
    assign o_out.out_byte = u2u_pkg::utf8_byte(r_cp, r_len, r_idx);
    assign o_out.run_last = last_byte;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp  <= i_head.cp;
            r_len <= u2u_pkg::utf8_len(i_head.cp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (xfer) begin
                if (last_byte) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= r_len)
        else $error("byte index past code point length");

    a_hold_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !last_byte) |=> $stable(r_cp) && r_busy)
        else $error("code point changed before its last byte");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && !last_byte) |=> r_idx == $past(r_idx) + 1'b1)
        else $error("byte index did not advance after transfer");

endmodule

/* rtl/utf16_to_utf8_transcoder.sv */
// Path: with the output side idle, the first UTF-8 byte of a code point reaches the output
//   from the input transfer that completes it through the queue write, then the output load.
// Throughput: one input byte per cycle while the queue has room; the output gives one byte
//   per cycle while o_out.ready is high, 1 to 4 per code point, so three-byte text (two input
//   bytes to three output bytes) slows the input and supplementary text (four to four) does not.
// Reset (synchronous, active low) clears pairing state, queue and byte order (little-endian).
module utf16_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = u2u_pkg::QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data,
    u2u_in_if.sink    i_in,
    u2u_out_if.source o_out
);

    u2u_pkg::t_q_push q_push;
    u2u_pkg::t_q_head q_head;
    logic             q_full;
    logic             q_pop;

    u2u_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (q_push)
    );

    u2u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    u2u_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule
